// ----- rtl/black_frame_rms_detector_core_macros.svh -----
// assertion macros shared by the black frame detector modules
`ifndef BLACK_FRAME_RMS_DETECTOR_CORE_MACROS_SVH
`define BLACK_FRAME_RMS_DETECTOR_CORE_MACROS_SVH

// condition that holds at every clock edge out of reset
`define BFRD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition in one cycle implies a condition in the next
`define BFRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bfrd_pkg.sv -----
// shared types, register codes and constant helpers for the black frame detector
`timescale 1ns / 1ps

package bfrd_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROI_LEFT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROI_TOP    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROI_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROI_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_SKIP   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 3'd5;

  // largest effective row skip
  localparam logic [2:0] SKIP_LIMIT = 3'd5;

  // reciprocal shifts for division by the row spacing
  localparam int ROW_SHIFT  = 17;
  localparam int AREA_SHIFT = 29;

  typedef struct packed {
    logic [7:0]  luma;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic        frame_end;
  } pixel_t;

  typedef struct packed {
    logic        is_black;
    logic [39:0] sum_squares;
    logic [24:0] sample_count;
  } result_t;

  typedef struct packed {
    logic [11:0] roi_left;
    logic [11:0] roi_top;
    logic [12:0] roi_width;
    logic [12:0] roi_height;
    logic [2:0]  row_skip;
    logic [15:0] threshold_q8;
  } cfg_t;

  // one classified pixel handed from front to back
  typedef struct packed {
    logic        frame_end;
    logic [15:0] square;
  } entry_t;

  // row spacing: saturated skip plus one, 1..6
  function automatic logic [2:0] spacing(input logic [2:0] skip);
    spacing = (skip > SKIP_LIMIT) ? SKIP_LIMIT + 3'd1 : skip + 3'd1;
  endfunction

  // ceil(2^17 / d), exact quotient for values below 2^13
  function automatic logic [17:0] recip_row(input logic [2:0] d);
    unique case (d)
      3'd1:    recip_row = 18'd131072;
      3'd2:    recip_row = 18'd65536;
      3'd3:    recip_row = 18'd43691;
      3'd4:    recip_row = 18'd32768;
      3'd5:    recip_row = 18'd26215;
      default: recip_row = 18'd21846;
    endcase
  endfunction

  // ceil(2^29 / d), exact quotient for values below 2^26
  function automatic logic [29:0] recip_area(input logic [2:0] d);
    unique case (d)
      3'd1:    recip_area = 30'd536870912;
      3'd2:    recip_area = 30'd268435456;
      3'd3:    recip_area = 30'd178956971;
      3'd4:    recip_area = 30'd134217728;
      3'd5:    recip_area = 30'd107374183;
      default: recip_area = 30'd89478486;
    endcase
  endfunction

  // (phase + 1) mod d on narrow values
  function automatic logic [2:0] next_phase(input logic [2:0] phase, input logic [2:0] d);
    logic [3:0] v;
    v = {1'b0, phase} + 4'd1;
    for (int i = 0; i < 8; i++) begin
      if (v >= {1'b0, d}) begin
        v = v - {1'b0, d};
      end
    end
    next_phase = v[2:0];
  endfunction

endpackage

// ----- rtl/bfrd_front.sv -----
// front part: accepts pixels, tests region and sampled row, squares luma
`timescale 1ns / 1ps

module bfrd_front (
  input  logic            clk,
  input  logic            rst,
  input  bfrd_pkg::cfg_t   cfg,
  input  logic            push,
  output logic            full,
  input  bfrd_pkg::pixel_t pixel,
  output logic            q_write,
  output bfrd_pkg::entry_t q_entry,
  input  logic            q_full
);
  import bfrd_pkg::*;

  logic [2:0]  d;
  logic [2:0]  frame_phase;
  logic        adv;
  logic        accept;

  logic [12:0] first_row;
  logic [11:0] col_off;
  logic        in_cols;
  logic        row_ok;
  logic [12:0] rel_full;

  logic        s1_valid;
  logic        s1_hit;
  logic [11:0] s1_rel;
  logic [7:0]  s1_luma;
  logic        s1_frame_end;

  logic [29:0] rel_prod;
  logic [30:0] h_prod;

  logic        s2_valid;
  logic        s2_hit;
  logic [11:0] s2_rel;
  logic [11:0] s2_q_rel;
  logic [12:0] s2_q_h;
  logic [7:0]  s2_luma;
  logic        s2_frame_end;

  logic [14:0] back_prod;
  logic        take;
  logic [15:0] square;

  assign d = spacing(cfg.row_skip);

  // whole pipe moves together unless the last stage is held by the queue
  assign adv    = !s2_valid || !q_full;
  assign full   = !adv;
  assign accept = push && adv;

  // region and row offset of the incoming pixel
  assign first_row = {1'b0, cfg.roi_top} + {10'b0, frame_phase};
  assign col_off   = pixel.pixel_col - cfg.roi_left;
  assign in_cols   = (pixel.pixel_col >= cfg.roi_left) && ({1'b0, col_off} < cfg.roi_width);
  assign row_ok    = {1'b0, pixel.pixel_row} >= first_row;
  assign rel_full  = {1'b0, pixel.pixel_row} - first_row;

  // frame phase steps on each accepted last pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase <= 3'd0;
    end else if (accept && pixel.frame_end) begin
      frame_phase <= next_phase(frame_phase, d);
    end
  end

  // stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_hit       <= in_cols && row_ok;
      s1_rel       <= rel_full[11:0];
      s1_luma      <= pixel.luma;
      s1_frame_end <= pixel.frame_end;
    end
  end

  // quotients of row offset and region height by the spacing
  assign rel_prod = 30'(s1_rel) * 30'(recip_row(d));
  assign h_prod   = 31'(cfg.roi_height) * 31'(recip_row(d));

  // stage two
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_hit       <= s1_hit;
      s2_rel       <= s1_rel;
      s2_q_rel     <= rel_prod[ROW_SHIFT +: 12];
      s2_q_h       <= h_prod[ROW_SHIFT +: 13];
      s2_luma      <= s1_luma;
      s2_frame_end <= s1_frame_end;
    end
  end

  // sampled row: offset is a multiple of the spacing and below the row count
  assign back_prod = 15'(s2_q_rel) * 15'(d);
  assign take      = s2_hit && (back_prod == {3'b0, s2_rel}) && ({1'b0, s2_q_rel} < s2_q_h);
  assign square    = 16'(s2_luma) * 16'(s2_luma);

  // only counted pixels and frame ends go to the back part
  assign q_write           = s2_valid && !q_full && (take || s2_frame_end);
  assign q_entry.frame_end = s2_frame_end;
  assign q_entry.square    = take ? square : 16'd0;

endmodule

// ----- rtl/bfrd_queue.sv -----
// short queue of classified pixels between front and back parts
`timescale 1ns / 1ps
`include "black_frame_rms_detector_core_macros.svh"

module bfrd_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             write,
  input  bfrd_pkg::entry_t entry_in,
  output logic             full,
  input  logic             read,
  output bfrd_pkg::entry_t entry_out,
  output logic             empty
);
  import bfrd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign full      = count == CW'(DEPTH);
  assign empty     = count == '0;
  assign do_wr     = write && !full;
  assign do_rd     = read && !empty;
  assign entry_out = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= entry_in;
    end
  end

  `BFRD_ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "queue count above depth")
  `BFRD_ASSERT_ALWAYS(a_no_write_full, !(write && full), "front wrote into a full queue")

endmodule

// ----- rtl/bfrd_back.sv -----
// back part: accumulates squares, judges the frame and holds the result
`timescale 1ns / 1ps
`include "black_frame_rms_detector_core_macros.svh"

module bfrd_back (
  input  logic              clk,
  input  logic              rst,
  input  bfrd_pkg::cfg_t    cfg,
  input  logic              q_empty,
  output logic              q_read,
  input  bfrd_pkg::entry_t  q_entry,
  output logic              empty,
  input  logic              pop,
  output bfrd_pkg::result_t result
);
  import bfrd_pkg::*;

  localparam logic [2:0] ST_ACC     = 3'd0;
  localparam logic [2:0] ST_AREA    = 3'd1;
  localparam logic [2:0] ST_COUNT   = 3'd2;
  localparam logic [2:0] ST_PRODUCT = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [2:0]  d;
  logic [39:0] sum;
  logic [40:0] sum_add;
  logic [39:0] sum_sat;
  logic        out_valid;
  logic        slot_free;
  logic        emit;

  logic [25:0] area;
  logic [31:0] thr_sq;
  logic [25:0] count;
  logic [57:0] limit;
  logic [55:0] count_prod;
  logic        black;

  assign d         = spacing(cfg.row_skip);
  assign q_read    = (state == ST_ACC) && !q_empty;
  assign slot_free = !out_valid || pop;
  assign emit      = (state == ST_EMIT) && slot_free;
  assign empty     = !out_valid;

  // saturating accumulate
  assign sum_add = {1'b0, sum} + 41'(q_entry.square);
  assign sum_sat = sum_add[40] ? '1 : sum_add[39:0];

  // sample count and threshold product
  assign count_prod = 56'(area) * 56'(recip_area(d));
  assign black      = 58'({sum, 16'h0000}) < limit;

  // frame-end sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACC: begin
        if (q_read && q_entry.frame_end) begin
          state_next = ST_AREA;
        end
      end
      ST_AREA:    state_next = ST_COUNT;
      ST_COUNT:   state_next = ST_PRODUCT;
      ST_PRODUCT: state_next = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_ACC;
        end
      end
      default:    state_next = ST_ACC;
    endcase
  end

  // control state and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_read) begin
        sum <= sum_sat;
      end else if (emit) begin
        sum <= '0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // arithmetic pipeline of the frame judgement
  always_ff @(posedge clk) begin
    if (state == ST_AREA) begin
      area   <= 26'(cfg.roi_width) * 26'(cfg.roi_height);
      thr_sq <= 32'(cfg.threshold_q8) * 32'(cfg.threshold_q8);
    end
    if (state == ST_COUNT) begin
      count <= count_prod[AREA_SHIFT +: 26];
    end
    if (state == ST_PRODUCT) begin
      limit <= 58'(thr_sq) * 58'(count);
    end
    if (emit) begin
      result.is_black     <= black;
      result.sum_squares  <= sum;
      result.sample_count <= count[24:0];
    end
  end

  `BFRD_ASSERT_NEXT(a_sum_cleared, emit, sum == '0, "sum not cleared after frame result")
  `BFRD_ASSERT_NEXT(a_result_source, !out_valid && (state != ST_EMIT), !out_valid, "result appeared outside emit")

endmodule

// ----- rtl/black_frame_rms_detector_core.sv -----
// Black frame detector by RMS level: luma pixels in, one verdict per frame out.
// Path: last pixel via front stages one and two and the queue into the back part, which
// holds for three multiply steps (area, count, product) and the emit; more if backed up.
// Throughput: one pixel per cycle while full is low; those frame-end steps can stall input.
// Reset: synchronous; clears configuration, valid flags, phase, sum, queue and result valid.
`timescale 1ns / 1ps

module black_frame_rms_detector_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  bfrd_pkg::pixel_t                    pixel,
  output logic                                empty,
  input  logic                                pop,
  output bfrd_pkg::result_t                   result,
  input  logic                                cfg_write,
  input  logic [bfrd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bfrd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bfrd_pkg::*;

  cfg_t   cfg;
  logic   q_write;
  entry_t q_in;
  logic   q_full;
  logic   q_read;
  entry_t q_out;
  logic   q_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROI_LEFT:   cfg.roi_left     <= cfg_data[11:0];
        REG_ROI_TOP:    cfg.roi_top      <= cfg_data[11:0];
        REG_ROI_WIDTH:  cfg.roi_width    <= cfg_data[12:0];
        REG_ROI_HEIGHT: cfg.roi_height   <= cfg_data[12:0];
        REG_ROW_SKIP:   cfg.row_skip     <= cfg_data[2:0];
        REG_THRESHOLD:  cfg.threshold_q8 <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  bfrd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .full    (full),
    .pixel   (pixel),
    .q_write (q_write),
    .q_entry (q_in),
    .q_full  (q_full)
  );

  bfrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .write     (q_write),
    .entry_in  (q_in),
    .full      (q_full),
    .read      (q_read),
    .entry_out (q_out),
    .empty     (q_empty)
  );

  bfrd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_read  (q_read),
    .q_entry (q_out),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
